// ===== hw/rtl/ism_pkg.sv =====
// Shared types, sizes and helpers for the image scale / mirror engine.
// No dependencies; every other file of the block but ism_chk imports this package.
package ism_pkg;

  localparam int MAX_DIM    = 64;
  localparam int PIXEL_BITS = 24;
  localparam int OUT_W      = 24;
  localparam int CFG_DIM_W  = 7;
  localparam int MODE_W     = 2;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int SUM_W      = DIM_W + 1;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int DIVD_W     = ADDR_W;
  localparam int DCNT_W     = $clog2(DIVD_W);
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_MODE       = 3'd4
  } ism_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESIZE   = 2'd0,
    MODE_ROT180   = 2'd1,
    MODE_MIRROR_H = 2'd2,
    MODE_MIRROR_V = 2'd3
  } ism_mode_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } ism_op_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] src_width;
    logic [CFG_DIM_W-1:0] src_height;
    logic [CFG_DIM_W-1:0] dst_width;
    logic [CFG_DIM_W-1:0] dst_height;
    ism_mode_e            mode;
  } ism_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIM_W-1:0]  divisor;
  } ism_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIM_W-1:0]  remainder;
  } ism_div_res_t;

  // Zero counts as one, anything above the store edge as the edge.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/image_scale_mirror_engine.sv =====
// Top level: setup sequencer, output coordinate counters, resize steppers
// and address generation. Depends on ism_pkg, ism_cfg, ism_div, ism_store.
//
//   port group         direction  handshake
//   start/opcode_i/    in         accepted when start high and busy low
//     pixel_in_i
//   result_valid_o/    out        one-cycle strobe, cannot be held off
//     pixel_out_o/last_o
//   psel..pready       in/out     APB-style register access, pready tied high
//
// A load or fetch is taken every cycle while busy is low; a fetch's pixel
// appears in the cycle after acceptance (registered store read).
// After reset and after every register write, busy stays high while the
// divider sets up the steppers
// (four 12-bit divisions, one quotient bit per cycle).
// Results are strobed for one cycle; the receiver cannot stall them.
module image_scale_mirror_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [23:0]                  pixel_in_i,
  output logic                         result_valid_o,
  output logic [23:0]                  pixel_out_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ism_pkg::APB_AW-1:0]   paddr,
  input  logic [ism_pkg::APB_DW-1:0]   pwdata,
  output logic [ism_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ism_pkg::*;

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_PREP = 4'b0010,
    S_LOAD = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    JOB_COL_POS  = 2'd0,
    JOB_ROW_POS  = 2'd1,
    JOB_COL_STEP = 2'd2,
    JOB_ROW_STEP = 2'd3
  } job_e;

  ism_cfg_t      cfg;
  logic          cfg_wr;
  ism_div_req_t  div_req;
  ism_div_res_t  div_res;

  state_e              state_q, state_d;
  job_e                job_q;
  logic [DIM_W-1:0]    sw_q, sh_q, ow_q, oh_q;
  logic [COUNT_W-1:0]  size_q, load_cnt_q;
  logic [COORD_W-1:0]  out_col_q, out_row_q;
  logic [COORD_W-1:0]  rsc_q, rsr_q;
  logic [DIM_W-1:0]    crem_q, rrem_q;
  logic [DIM_W-1:0]    qc_q, rc_q, qr_q, rr_q;
  logic                res_valid_q, last_q;

  logic [DIM_W-1:0]    sw_new, sh_new, ow_new, oh_new;
  logic                take, do_load, do_fetch, load_ok;
  logic                col_last, row_last, is_last;
  logic [COORD_W-1:0]  col_eff, row_eff;
  logic [COORD_W-1:0]  sc, sr;
  logic [ADDR_W-1:0]   raddr;
  logic [SUM_W-1:0]    crem_sum, rrem_sum;
  logic                c_carry, r_carry;
  logic [PIXEL_BITS-1:0] rdata;

  ism_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  ism_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  ism_store u_store (
    .clk_i   (clk_i),
    .we_i    (do_load & load_ok),
    .waddr_i (load_cnt_q[ADDR_W-1:0]),
    .wdata_i (PIXEL_BITS'(pixel_in_i)),
    .re_i    (do_fetch),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Effective sizes from the register bank
  always_comb begin
    sw_new = clamp_dim(cfg.src_width);
    sh_new = clamp_dim(cfg.src_height);
    if (cfg.mode == MODE_RESIZE) begin
      ow_new = clamp_dim(cfg.dst_width);
      oh_new = clamp_dim(cfg.dst_height);
    end else begin
      ow_new = sw_new;
      oh_new = sh_new;
    end
  end

  // Counters left beyond a shrunk picture count as its last column or row
  always_comb begin
    col_eff = (DIM_W'(out_col_q) >= ow_q) ? COORD_W'(ow_q - DIM_W'(1)) : out_col_q;
    row_eff = (DIM_W'(out_row_q) >= oh_q) ? COORD_W'(oh_q - DIM_W'(1)) : out_row_q;
  end

  assign busy     = (state_q != S_RUN);
  assign take     = start & ~busy;
  assign do_load  = take & (ism_op_e'(opcode_i) == OP_LOAD);
  assign do_fetch = take & (ism_op_e'(opcode_i) == OP_FETCH);
  assign load_ok  = load_cnt_q < size_q;

  // Divider jobs: current source position, then per-step quotient and remainder
  always_comb begin
    div_req.start = (state_q == S_LOAD);
    case (job_q)
      JOB_COL_POS: begin
        div_req.dividend = DIVD_W'(DIVD_W'(col_eff) * DIVD_W'(sw_q));
        div_req.divisor  = ow_q;
      end
      JOB_ROW_POS: begin
        div_req.dividend = DIVD_W'(DIVD_W'(row_eff) * DIVD_W'(sh_q));
        div_req.divisor  = oh_q;
      end
      JOB_COL_STEP: begin
        div_req.dividend = DIVD_W'(sw_q);
        div_req.divisor  = ow_q;
      end
      default: begin
        div_req.dividend = DIVD_W'(sh_q);
        div_req.divisor  = oh_q;
      end
    endcase
  end

  // Source coordinate and store address of the current output pixel
  always_comb begin
    col_last = DIM_W'(col_eff) == ow_q - DIM_W'(1);
    row_last = DIM_W'(row_eff) == oh_q - DIM_W'(1);
    is_last  = col_last & row_last;
    case (cfg.mode)
      MODE_RESIZE: begin
        sc = rsc_q;
        sr = rsr_q;
      end
      MODE_ROT180: begin
        sc = COORD_W'(sw_q - DIM_W'(1) - DIM_W'(col_eff));
        sr = COORD_W'(sh_q - DIM_W'(1) - DIM_W'(row_eff));
      end
      MODE_MIRROR_H: begin
        sc = COORD_W'(sw_q - DIM_W'(1) - DIM_W'(col_eff));
        sr = row_eff;
      end
      default: begin
        sc = col_eff;
        sr = COORD_W'(sh_q - DIM_W'(1) - DIM_W'(row_eff));
      end
    endcase
    raddr    = ADDR_W'(ADDR_W'(sr) * ADDR_W'(sw_q)) + ADDR_W'(sc);
    crem_sum = SUM_W'(crem_q) + SUM_W'(rc_q);
    rrem_sum = SUM_W'(rrem_q) + SUM_W'(rr_q);
    c_carry  = crem_sum >= SUM_W'(ow_q);
    r_carry  = rrem_sum >= SUM_W'(oh_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_RUN:  state_d = S_RUN;
      S_PREP: state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_res.done) begin
          state_d = (job_q == JOB_ROW_STEP) ? S_RUN : S_LOAD;
        end
      end
      default: state_d = S_PREP;
    endcase
    if (cfg_wr) begin
      state_d = S_PREP;
    end
  end

  assign result_valid_o = res_valid_q;
  assign last_o         = res_valid_q & last_q;
  assign pixel_out_o    = OUT_W'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PREP;
      job_q       <= JOB_COL_POS;
      sw_q        <= DIM_W'(1);
      sh_q        <= DIM_W'(1);
      ow_q        <= DIM_W'(1);
      oh_q        <= DIM_W'(1);
      size_q      <= '0;
      load_cnt_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      rsc_q       <= '0;
      rsr_q       <= '0;
      crem_q      <= '0;
      rrem_q      <= '0;
      qc_q        <= '0;
      rc_q        <= '0;
      qr_q        <= '0;
      rr_q        <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= do_fetch;

      if (state_q == S_PREP) begin
        // Latch sizes; the output counters keep their values
        sw_q   <= sw_new;
        sh_q   <= sh_new;
        ow_q   <= ow_new;
        oh_q   <= oh_new;
        size_q <= COUNT_W'(COUNT_W'(sw_new) * COUNT_W'(sh_new));
        job_q  <= JOB_COL_POS;
      end

      if (state_q == S_DIV && div_res.done) begin
        case (job_q)
          JOB_COL_POS: begin
            rsc_q  <= COORD_W'(div_res.quotient);
            crem_q <= div_res.remainder;
            job_q  <= JOB_ROW_POS;
          end
          JOB_ROW_POS: begin
            rsr_q  <= COORD_W'(div_res.quotient);
            rrem_q <= div_res.remainder;
            job_q  <= JOB_COL_STEP;
          end
          JOB_COL_STEP: begin
            qc_q  <= DIM_W'(div_res.quotient);
            rc_q  <= div_res.remainder;
            job_q <= JOB_ROW_STEP;
          end
          default: begin
            qr_q  <= DIM_W'(div_res.quotient);
            rr_q  <= div_res.remainder;
            job_q <= JOB_COL_POS;
          end
        endcase
      end

      if (do_load && load_ok) begin
        load_cnt_q <= load_cnt_q + COUNT_W'(1);
      end

      if (do_fetch) begin
        last_q <= is_last;
        if (col_last) begin
          out_col_q <= '0;
          rsc_q     <= '0;
          crem_q    <= '0;
          if (row_last) begin
            out_row_q <= '0;
            rsr_q     <= '0;
            rrem_q    <= '0;
          end else begin
            // Advance the row stepper by quotient plus carry
            out_row_q <= row_eff + COORD_W'(1);
            if (r_carry) begin
              rrem_q <= DIM_W'(rrem_sum - SUM_W'(oh_q));
              rsr_q  <= COORD_W'(DIM_W'(rsr_q) + qr_q + DIM_W'(1));
            end else begin
              rrem_q <= DIM_W'(rrem_sum);
              rsr_q  <= COORD_W'(DIM_W'(rsr_q) + qr_q);
            end
          end
        end else begin
          out_col_q <= col_eff + COORD_W'(1);
          out_row_q <= row_eff;
          if (c_carry) begin
            crem_q <= DIM_W'(crem_sum - SUM_W'(ow_q));
            rsc_q  <= COORD_W'(DIM_W'(rsc_q) + qc_q + DIM_W'(1));
          end else begin
            crem_q <= DIM_W'(crem_sum);
            rsc_q  <= COORD_W'(DIM_W'(rsc_q) + qc_q);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ism_cfg.sv =====
// Register bank behind the APB-style port: sizes and mode.
// Depends on ism_pkg.
module ism_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ism_pkg::APB_AW-1:0]  paddr,
  input  logic [ism_pkg::APB_DW-1:0]  pwdata,
  output logic [ism_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ism_pkg::ism_cfg_t           cfg_o,
  output logic                        cfg_wr_o
);
  import ism_pkg::*;

  ism_cfg_t                cfg_q, cfg_d;
  logic [REG_IDX_W-1:0]    idx;
  logic                    wr_en;

  assign pready   = 1'b1;
  assign idx      = paddr[APB_AW-1:2];
  assign wr_en    = psel & penable & pwrite;
  assign cfg_wr_o = wr_en;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (ism_reg_e'(idx))
        REG_SRC_WIDTH:  cfg_d.src_width  = pwdata[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: cfg_d.src_height = pwdata[CFG_DIM_W-1:0];
        REG_DST_WIDTH:  cfg_d.dst_width  = pwdata[CFG_DIM_W-1:0];
        REG_DST_HEIGHT: cfg_d.dst_height = pwdata[CFG_DIM_W-1:0];
        REG_MODE:       cfg_d.mode       = ism_mode_e'(pwdata[MODE_W-1:0]);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (ism_reg_e'(idx))
      REG_SRC_WIDTH:  prdata = APB_DW'(cfg_q.src_width);
      REG_SRC_HEIGHT: prdata = APB_DW'(cfg_q.src_height);
      REG_DST_WIDTH:  prdata = APB_DW'(cfg_q.dst_width);
      REG_DST_HEIGHT: prdata = APB_DW'(cfg_q.dst_height);
      REG_MODE:       prdata = APB_DW'(cfg_q.mode);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= CFG_DIM_W'(64);
      cfg_q.src_height <= CFG_DIM_W'(64);
      cfg_q.dst_width  <= CFG_DIM_W'(64);
      cfg_q.dst_height <= CFG_DIM_W'(64);
      cfg_q.mode       <= MODE_RESIZE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/ism_div.sv =====
// Restoring divider, one quotient bit per cycle, used to set up the
// resize steppers. Depends on ism_pkg.
module ism_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ism_pkg::ism_div_req_t req_i,
  output ism_pkg::ism_div_res_t res_o
);
  import ism_pkg::*;

  logic                active_q;
  logic                done_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic [DIVD_W-1:0]   quo_q, quo_d;
  logic [DIM_W-1:0]    rem_q, rem_d;
  logic [DIM_W-1:0]    dvs_q;
  logic [SUM_W-1:0]    trial;
  logic                ge;

  always_comb begin
    trial = {rem_q, quo_q[DIVD_W-1]};
    ge    = trial >= SUM_W'(dvs_q);
    rem_d = ge ? DIM_W'(trial - SUM_W'(dvs_q)) : DIM_W'(trial);
    quo_d = {quo_q[DIVD_W-2:0], ge};
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (active_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/ism_store.sv =====
// Pixel frame store: one write port, one read port, registered read data.
// Depends on ism_pkg.
module ism_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ism_pkg::ADDR_W-1:0]     waddr_i,
  input  logic [ism_pkg::PIXEL_BITS-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [ism_pkg::ADDR_W-1:0]     raddr_i,
  output logic [ism_pkg::PIXEL_BITS-1:0] rdata_o
);
  import ism_pkg::*;

  logic [PIXEL_BITS-1:0] mem [2**ADDR_W];
  logic [PIXEL_BITS-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/ism_chk.sv =====
// Port-level assertions for the image scale / mirror engine, bound to the
// top level. Depends on image_scale_mirror_engine.
module ism_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic opcode_i,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic result_valid_o,
  input logic last_o
);

  // Every fetch item gives exactly one strobe, in the following cycle
  a_fetch_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i) |=> result_valid_o)
    else $error("fetch item without result strobe");

  a_result_from_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && opcode_i))
    else $error("result strobe without a fetch item");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !opcode_i) |=> !result_valid_o)
    else $error("load item produced a result");

  a_last_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last flagged outside a result");

  // Register writes start the setup pass
  a_write_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("register write did not raise busy");

endmodule

bind image_scale_mirror_engine ism_chk u_ism_chk (.*);

// ===== bench/image_scale_mirror_engine_test.sv =====
// Self-checking bench for image_scale_mirror_engine: loads source pictures, fetches
// resized, rotated and mirrored pixels and checks each one against an in-bench model.
// Depends on ism_pkg and the engine RTL only.
`timescale 1ns / 100ps

module image_scale_mirror_engine_test;
  import ism_pkg::*;

  typedef struct packed {
    ism_op_e     op;
    logic [23:0] pix;
  } pixel_cmd_t;

  typedef struct packed {
    logic [23:0] pix;
    logic        last;
  } pixel_due_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode_i = 1'b0;
  logic [23:0]         pixel_in_i = '0;
  logic                result_valid_o;
  logic [23:0]         pixel_out_o;
  logic                last_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Model of the engine: register copies, pixel store and output counters
  logic [CFG_DIM_W-1:0] cfg_src_w = 7'd64;
  logic [CFG_DIM_W-1:0] cfg_src_h = 7'd64;
  logic [CFG_DIM_W-1:0] cfg_dst_w = 7'd64;
  logic [CFG_DIM_W-1:0] cfg_dst_h = 7'd64;
  ism_mode_e            cfg_mode = MODE_RESIZE;
  logic [23:0]          store_img [0:MAX_DIM*MAX_DIM-1];
  int                   fill_cnt = 0;
  int                   out_x = 0;
  int                   out_y = 0;

  pixel_cmd_t pending_cmds [$];
  pixel_due_t pixel_due_q [$];
  int         mismatch_cnt = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         planned_fill = 0;
  int         issued = 0;

  image_scale_mirror_engine uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .pixel_in_i     (pixel_in_i),
    .result_valid_o (result_valid_o),
    .pixel_out_o    (pixel_out_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int eff_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > 7'd64) return MAX_DIM;
    return int'(v);
  endfunction

  // Apply one accepted item to the model; a fetch queues the pixel it must return
  task automatic advance_scaler(input ism_op_e op, input logic [23:0] pix);
    int sw, sh, ow, oh, col, row, sc, sr;
    pixel_due_t due;
    sw = eff_dim(cfg_src_w);
    sh = eff_dim(cfg_src_h);
    if (op == OP_LOAD) begin
      if (fill_cnt < sw * sh) begin
        store_img[fill_cnt] = pix;
        fill_cnt++;
      end
    end else begin
      ow = (cfg_mode == MODE_RESIZE) ? eff_dim(cfg_dst_w) : sw;
      oh = (cfg_mode == MODE_RESIZE) ? eff_dim(cfg_dst_h) : sh;
      // counters left beyond a shrunk picture stick to its edge
      col = (out_x < ow) ? out_x : ow - 1;
      row = (out_y < oh) ? out_y : oh - 1;
      case (cfg_mode)
        MODE_RESIZE: begin
          sc = (col * sw) / ow;
          sr = (row * sh) / oh;
        end
        MODE_ROT180: begin
          sc = sw - 1 - col;
          sr = sh - 1 - row;
        end
        MODE_MIRROR_H: begin
          sc = sw - 1 - col;
          sr = row;
        end
        default: begin
          sc = col;
          sr = sh - 1 - row;
        end
      endcase
      due.pix = store_img[sr * sw + sc];
      due.last = (col == ow - 1) && (row == oh - 1);
      pixel_due_q.insert(pixel_due_q.size(), due);
      if (col == ow - 1) begin
        out_x = 0;
        out_y = due.last ? 0 : row + 1;
      end else begin
        out_x = col + 1;
        out_y = row;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) burst_left = $urandom_range(30, 120);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin : drive_cmds
    logic go;
    pixel_cmd_t cmd;
    if (rst_ni) begin
      go = start;
      if (start && !busy) begin
        advance_scaler(ism_op_e'(opcode_i), pixel_in_i);
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          cmd = pending_cmds.pop_front();
          opcode_i <= cmd.op;
          pixel_in_i <= cmd.pix;
          go = 1'b1;
          gap_left = pick_gap();
        end
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin : check_pixels
    pixel_due_t due;
    if (rst_ni && result_valid_o) begin
      if (pixel_due_q.size() == 0) begin
        $display("%0t ns: pixel %h last %b arrived with nothing expected",
                 $time, pixel_out_o, last_o);
        mismatch_cnt++;
      end else begin
        due = pixel_due_q.pop_front();
        if (pixel_out_o !== due.pix || last_o !== due.last) begin
          $display("%0t ns: expected pixel %h last %b, got pixel %h last %b",
                   $time, due.pix, due.last, pixel_out_o, last_o);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic logic [23:0] rand_pixel();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  // Queue one item; loads past the picture are dropped by the engine and not counted
  task automatic push_item(input ism_op_e op, input logic [23:0] pix);
    pixel_cmd_t cmd;
    cmd.op = op;
    cmd.pix = pix;
    pending_cmds.insert(pending_cmds.size(), cmd);
    if (op == OP_FETCH) begin
      issued++;
    end else if (planned_fill < eff_dim(cfg_src_w) * eff_dim(cfg_src_h)) begin
      planned_fill++;
      issued++;
    end
  endtask

  // Drain all items, collect outstanding pixels, then wait for the engine to go idle
  task automatic settle();
    int spins;
    while (pending_cmds.size() != 0 || start) @(negedge clk_i);
    spins = 0;
    while (pixel_due_q.size() != 0 && spins < 200) begin
      @(negedge clk_i);
      spins++;
    end
    if (pixel_due_q.size() != 0) begin
      $display("%0t ns: %0d expected pixels never came, first expected %h last %b",
               $time, pixel_due_q.size(), pixel_due_q[0].pix, pixel_due_q[0].last);
      mismatch_cnt++;
      pixel_due_q.delete();
    end
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input ism_reg_e r, input logic [CFG_DIM_W-1:0] v);
    logic [31:0] junk;
    settle();
    junk = $urandom();
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= {junk[31:CFG_DIM_W], v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_SRC_WIDTH:  cfg_src_w = v;
      REG_SRC_HEIGHT: cfg_src_h = v;
      REG_DST_WIDTH:  cfg_dst_w = v;
      REG_DST_HEIGHT: cfg_dst_h = v;
      default:        cfg_mode = ism_mode_e'(v[MODE_W-1:0]);
    endcase
    @(negedge clk_i);
  endtask

  function automatic int pick_size(input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 1;
    if (r < 3) return hi;
    return $urandom_range(1, hi);
  endfunction

  // Sizes of one and of the store edge have several register codings
  function automatic logic [CFG_DIM_W-1:0] encode_size(input int d);
    if (d == 1) return 7'($urandom_range(0, 1));
    if (d == MAX_DIM) begin
      if ($urandom_range(0, 3) == 0) return 7'd127;
      return 7'($urandom_range(64, 127));
    end
    return 7'(d);
  endfunction

  initial begin
    int sw, sh, dw, dh, room, pic, nf;
    ism_mode_e md;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-pixel source blown up to 3x2, then the flips on it
    write_reg(REG_SRC_WIDTH, 7'd0);
    write_reg(REG_SRC_HEIGHT, 7'd1);
    write_reg(REG_DST_WIDTH, 7'd3);
    write_reg(REG_DST_HEIGHT, 7'd2);
    write_reg(REG_MODE, 7'(MODE_RESIZE));
    push_item(OP_LOAD, 24'hFFFFFF);
    push_item(OP_LOAD, 24'h000000);
    repeat (7) push_item(OP_FETCH, rand_pixel());
    write_reg(REG_MODE, 7'(MODE_ROT180));
    push_item(OP_FETCH, 24'hFFFFFF);
    write_reg(REG_MODE, 7'(MODE_MIRROR_H));
    push_item(OP_FETCH, 24'h000000);
    write_reg(REG_MODE, 7'(MODE_MIRROR_V));
    push_item(OP_FETCH, rand_pixel());

    // grow to 3x2 and mirror it left-right
    write_reg(REG_SRC_WIDTH, 7'd3);
    write_reg(REG_SRC_HEIGHT, 7'd2);
    write_reg(REG_MODE, 7'(MODE_MIRROR_H));
    push_item(OP_LOAD, 24'h000000);
    push_item(OP_LOAD, 24'h555555);
    push_item(OP_LOAD, 24'hAAAAAA);
    push_item(OP_LOAD, 24'h0F0F0F);
    push_item(OP_LOAD, 24'hF0F0F0);
    repeat (6) push_item(OP_FETCH, rand_pixel());

    // random phases: new sizes and mode, top up the store, fetch whole and part pictures
    while (issued < 1250) begin
      sw = pick_size(MAX_DIM);
      room = planned_fill + ((planned_fill < 600) ? $urandom_range(0, 48) : 0);
      if (room < sw) room = sw;
      sh = pick_size((room / sw > MAX_DIM) ? MAX_DIM : room / sw);
      if ($urandom_range(0, 9) < 7) begin
        dw = pick_size(12);
        dh = pick_size(12);
      end else begin
        dw = pick_size(MAX_DIM);
        dh = pick_size(MAX_DIM);
      end
      md = ism_mode_e'($urandom_range(0, 3));
      write_reg(REG_SRC_WIDTH, encode_size(sw));
      write_reg(REG_SRC_HEIGHT, encode_size(sh));
      write_reg(REG_DST_WIDTH, encode_size(dw));
      write_reg(REG_DST_HEIGHT, encode_size(dh));
      write_reg(REG_MODE, {5'($urandom()), md});
      while (planned_fill < sw * sh) push_item(OP_LOAD, rand_pixel());
      repeat ($urandom_range(0, 3)) push_item(OP_LOAD, rand_pixel());
      pic = (md == MODE_RESIZE) ? dw * dh : sw * sh;
      if (pic <= 100) nf = pic * $urandom_range(1, 2) + $urandom_range(0, pic);
      else nf = $urandom_range(30, 100);
      repeat (nf) begin
        // stray loads between fetches land past the picture
        if ($urandom_range(0, 9) == 0) push_item(OP_LOAD, rand_pixel());
        else push_item(OP_FETCH, rand_pixel());
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
